@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every enabled clock edge
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ sv/socc_pkg.sv @@
// ----------------------------------------------------------------------------
// socc_pkg
// Sizes, field types and codes for the segment obstacle collision check.
// ----------------------------------------------------------------------------
package socc_pkg;

    // Table depth and coordinate precision
    localparam int MAX_OBSTACLES = 64;
    localparam int COORD_BITS    = 16;

    // Fixed port field widths
    localparam int FIELD_W  = 16;
    localparam int SLOT_W   = 6;
    localparam int ACTIVE_W = 7;

    // Derived widths
    localparam int IDX_W   = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int CNT_W   = $clog2(MAX_OBSTACLES + 1);
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;

    typedef logic signed [FIELD_W-1:0]    t_field;
    typedef logic        [SLOT_W-1:0]     t_slot;
    typedef logic        [ACTIVE_W-1:0]   t_active;
    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [PROD_W-1:0]     t_prod;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'd0,
        ST_CLEAR = 2'd1,
        ST_HIT   = 2'd2
    } t_status;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    typedef struct packed {
        t_point p1;
        t_point p2;
    } t_segment;

endpackage

@@ sv/socc_if.sv @@
// ----------------------------------------------------------------------------
// socc channel interfaces
// Request, response and configuration channels with valid/ready transfer.
// ----------------------------------------------------------------------------

// Request channel: obstacle load or edge query
interface socc_req_if;
    import socc_pkg::*;

    logic      valid;
    logic      ready;
    t_req_type req_type;
    t_slot     slot;
    t_field    first_x;
    t_field    first_y;
    t_field    second_x;
    t_field    second_y;

    modport source (
        output valid, req_type, slot, first_x, first_y, second_x, second_y,
        input  ready
    );
    modport sink (
        input  valid, req_type, slot, first_x, first_y, second_x, second_y,
        output ready
    );
endinterface

// Response channel: one result per request
interface socc_rsp_if;
    import socc_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_slot   hit_slot;

    modport source (output valid, status, hit_slot, input ready);
    modport sink   (input valid, status, hit_slot, output ready);
endinterface

// Configuration write channel: active obstacle count
interface socc_cfg_if;
    import socc_pkg::*;

    logic    valid;
    logic    ready;
    t_active data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ sv/segment_obstacle_collision_check.sv @@
// ----------------------------------------------------------------------------
// segment_obstacle_collision_check
// Obstacle segment table with a strict-crossing test for candidate edges.
// ----------------------------------------------------------------------------
// A load request writes one obstacle into the 64-entry table; its result
// (status load) passes through the finish state to the output register. A
// query tests the edge against slots 0 to active_obstacles-1 (saturated to
// the table depth) and stops at the first strict crossing. Each obstacle
// takes one table read plus nine steps of the single shared 17x17
// multiplier and comparator that compute the four orientation signs. The
// request side is ready only between items; a finished result waits in the
// output register while the next request is taken and processed. Touching
// and collinear cases count as clear.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_obstacle_collision_check (
    input  logic      i_clk,
    input  logic      i_rst_n,
    socc_req_if.sink  i_req,
    socc_rsp_if.source o_rsp,
    socc_cfg_if.sink  i_cfg
);
    import socc_pkg::*;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;
    localparam t_step LAST_STEP = t_step'(8);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_ORIENT = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    t_active              r_active;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_idx;
    t_step                r_step;
    t_segment             r_edge;
    t_segment             r_entry;
    t_segment             r_obst_mem [MAX_OBSTACLES];
    t_prod                r_prod;
    t_prod                r_pa;
    logic [2:0]           r_pos;
    logic [2:0]           r_neg;
    t_status              r_res_status;
    t_slot                r_res_slot;
    logic                 r_out_valid;
    t_status              r_out_status;
    t_slot                r_out_slot;

    logic                 in_fire;
    logic                 is_load;
    logic                 out_free;
    logic [CNT_W-1:0]     cnt_sat;
    logic [1:0]           orient_sel;
    t_point               pt_i, pt_j, pt_k;
    t_diff                mul_a, mul_b;
    t_prod                prod;
    logic                 gt, lt;
    logic                 cut;
    logic                 last_obst;
    logic                 step_last;

    // Handshake
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_req.valid && i_req.ready;
    assign is_load     = (i_req.req_type == REQ_LOAD);
    assign out_free    = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.hit_slot = r_out_slot;

    // Active count saturated to the table depth
    always_comb begin
        if (32'(r_active) > MAX_OBSTACLES) begin
            cnt_sat = CNT_W'(MAX_OBSTACLES);
        end else begin
            cnt_sat = CNT_W'(r_active);
        end
    end

    // Operand select for the shared multiplier: orientation r_step[2:1],
    // first or second cross term by r_step[0]
    assign orient_sel = r_step[2:1];

    always_comb begin
        case (orient_sel)
            2'd0: begin
                pt_i = r_entry.p1; pt_j = r_entry.p2; pt_k = r_edge.p1;
            end
            2'd1: begin
                pt_i = r_entry.p1; pt_j = r_entry.p2; pt_k = r_edge.p2;
            end
            2'd2: begin
                pt_i = r_edge.p1;  pt_j = r_edge.p2;  pt_k = r_entry.p1;
            end
            default: begin
                pt_i = r_edge.p1;  pt_j = r_edge.p2;  pt_k = r_entry.p2;
            end
        endcase
    end

    always_comb begin
        if (!r_step[0]) begin
            mul_a = t_diff'(pt_k.x) - t_diff'(pt_i.x);
            mul_b = t_diff'(pt_j.y) - t_diff'(pt_i.y);
        end else begin
            mul_a = t_diff'(pt_j.x) - t_diff'(pt_i.x);
            mul_b = t_diff'(pt_k.y) - t_diff'(pt_i.y);
        end
    end

    assign prod = mul_a * mul_b;

    // Orientation sign from the registered cross-term pair
    assign gt = (r_pa > r_prod);
    assign lt = (r_pa < r_prod);

    // Strict straddle both ways; fourth sign comes straight from the compare
    assign cut = ((r_pos[0] && r_neg[1]) || (r_neg[0] && r_pos[1]))
              && ((r_pos[2] && lt) || (r_neg[2] && gt));

    assign step_last = (r_step == LAST_STEP);
    assign last_obst = (CNT_W'(r_idx + 1'b1) == r_count);

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (is_load || (cnt_sat == '0)) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_ORIENT;
            end
            S_ORIENT: begin
                if (step_last) begin
                    if (cut || last_obst) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid && i_cfg.ready) begin
                r_active <= i_cfg.data;
            end

            if ((r_state == S_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            // Obstacle and step counters
            if (in_fire) begin
                r_idx <= '0;
            end else if ((r_state == S_ORIENT) && step_last && !cut && !last_obst) begin
                r_idx <= r_idx + 1'b1;
            end

            if (r_state == S_READ) begin
                r_step <= '0;
            end else if ((r_state == S_ORIENT) && !step_last) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_edge.p1.x  <= t_coord'(i_req.first_x);
            r_edge.p1.y  <= t_coord'(i_req.first_y);
            r_edge.p2.x  <= t_coord'(i_req.second_x);
            r_edge.p2.y  <= t_coord'(i_req.second_y);
            r_count      <= cnt_sat;
            r_res_slot   <= '0;
            r_res_status <= is_load ? ST_LOAD : ST_CLEAR;
        end

        if ((r_state == S_ORIENT) && !step_last) begin
            r_prod <= prod;
            if (r_step[0]) begin
                r_pa <= r_prod;
            end
            if (!r_step[0] && (r_step != '0)) begin
                r_pos[orient_sel - 2'd1] <= gt;
                r_neg[orient_sel - 2'd1] <= lt;
            end
        end

        if ((r_state == S_ORIENT) && step_last && cut) begin
            r_res_status <= ST_HIT;
            r_res_slot   <= SLOT_W'(r_idx);
        end

        if ((r_state == S_FINISH) && out_free) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
        end
    end

    // Obstacle table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (in_fire && is_load && (32'(i_req.slot) < MAX_OBSTACLES)) begin
            r_obst_mem[IDX_W'(i_req.slot)] <= {
                t_coord'(i_req.first_x), t_coord'(i_req.first_y),
                t_coord'(i_req.second_x), t_coord'(i_req.second_y)
            };
        end
        r_entry <= r_obst_mem[r_idx[IDX_W-1:0]];
    end

    // Checks
    `ASSERT_IMPL(a_idx_in_range, i_clk, i_rst_n, r_state == S_ORIENT, r_idx < r_count, "obstacle index past active count")
    `ASSERT_IMPL(a_step_bound, i_clk, i_rst_n, r_state == S_ORIENT, r_step <= LAST_STEP, "orientation step overrun")
    `ASSERT_NEXT(a_load_finish, i_clk, i_rst_n, in_fire && is_load, r_state == S_FINISH, "load did not finish in one cycle")
    `ASSERT_IMPL(a_clear_slot_zero, i_clk, i_rst_n, o_rsp.valid && (o_rsp.status != ST_HIT), o_rsp.hit_slot == '0, "nonzero slot on a non-hit result")

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Loads obstacle segments and sends edge queries to the collision checker.
// A local predictor with its own copy of the obstacle table and the active
// count derives the expected status and hit slot of every transfer. Results
// are checked in order, and the run covers several active counts and idle
// patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import socc_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 700;
    localparam int HOLD_CYCLES  = 400;
    localparam int PRINT_CAP    = 50;

    // Idle pattern of the two channels
    typedef enum int {
        PACE_RX_SLOW,
        PACE_TX_SLOW,
        PACE_FULL
    } t_pace;

    // Coordinate flavors for generated segments
    typedef enum int {
        GEO_FULL,
        GEO_NEAR,
        GEO_MID,
        GEO_EXTREME
    } t_geo;

    typedef struct packed {
        t_req_type kind;
        t_slot     slot;
        t_field    ax;
        t_field    ay;
        t_field    bx;
        t_field    by;
    } t_request;

    typedef struct packed {
        t_status status;
        t_slot   hit_slot;
    } t_verdict;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    socc_req_if req_ch ();
    socc_rsp_if rsp_ch ();
    socc_cfg_if cfg_ch ();

    // Stimulus and expectation stores
    t_request pending_reqs[$];
    t_verdict expected_verdicts[$];

    // Predictor state
    t_segment obstacle_tab [MAX_OBSTACLES];
    t_active  active_cnt;

    // Generator shadow of the table, used to aim edges at known obstacles
    t_segment                 scene_tab [MAX_OBSTACLES];
    logic [MAX_OBSTACLES-1:0] scene_loaded = '0;

    t_pace pace         = PACE_RX_SLOW;
    int    error_count  = 0;
    int    cycle_count  = 0;
    int    result_count = 0;
    int    holds_asked  = 0;
    int    holds_served = 0;
    int    hold_left    = 0;

    segment_obstacle_collision_check dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("MISMATCH cycle %0d result %0d: %s", cycle_count, result_count, what);
    endtask

    function automatic int idle_pct(t_pace p, bit rx_side);
        case (p)
            PACE_RX_SLOW: return rx_side ? 67 : 10;
            PACE_TX_SLOW: return rx_side ? 10 : 67;
            default:      return 0;
        endcase
    endfunction

    // Sign of (k - i) x (j - i)
    function automatic int orient_sign(longint ix, longint iy, longint jx, longint jy,
                                       longint kx, longint ky);
        longint lhs;
        longint rhs;
        lhs = (kx - ix) * (jy - iy);
        rhs = (jx - ix) * (ky - iy);
        return (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
    endfunction

    // Applies one accepted request to the predictor and returns its result
    function automatic t_verdict predict_outcome(t_request rq);
        t_verdict v;
        int       limit;
        int       d1, d2, d3, d4;
        longint   ex1, ey1, ex2, ey2;
        longint   qx1, qy1, qx2, qy2;
        v.status   = ST_LOAD;
        v.hit_slot = '0;
        if (rq.kind == REQ_LOAD) begin
            obstacle_tab[rq.slot].p1.x = rq.ax;
            obstacle_tab[rq.slot].p1.y = rq.ay;
            obstacle_tab[rq.slot].p2.x = rq.bx;
            obstacle_tab[rq.slot].p2.y = rq.by;
            return v;
        end
        v.status = ST_CLEAR;
        qx1 = $signed(rq.ax);
        qy1 = $signed(rq.ay);
        qx2 = $signed(rq.bx);
        qy2 = $signed(rq.by);
        // count above the table depth saturates
        limit = (active_cnt > MAX_OBSTACLES) ? MAX_OBSTACLES : int'(active_cnt);
        for (int i = 0; i < limit; i++) begin
            ex1 = $signed(obstacle_tab[i].p1.x);
            ey1 = $signed(obstacle_tab[i].p1.y);
            ex2 = $signed(obstacle_tab[i].p2.x);
            ey2 = $signed(obstacle_tab[i].p2.y);
            d1 = orient_sign(ex1, ey1, ex2, ey2, qx1, qy1);
            d2 = orient_sign(ex1, ey1, ex2, ey2, qx2, qy2);
            d3 = orient_sign(qx1, qy1, qx2, qy2, ex1, ey1);
            d4 = orient_sign(qx1, qy1, qx2, qy2, ex2, ey2);
            // strict straddle both ways; zero signs mean touch or collinear
            if (d1 * d2 < 0 && d3 * d4 < 0) begin
                v.status   = ST_HIT;
                v.hit_slot = t_slot'(i);
                return v;
            end
        end
        return v;
    endfunction

    function automatic t_geo pick_geo();
        int r;
        r = $urandom_range(99);
        if (r < 25) return GEO_FULL;
        if (r < 65) return GEO_NEAR;
        if (r < 90) return GEO_MID;
        return GEO_EXTREME;
    endfunction

    function automatic t_field pick_coord(t_geo g);
        case (g)
            GEO_FULL: return t_field'($urandom());
            GEO_NEAR: return t_field'(int'($urandom_range(128)) - 64);
            GEO_MID:  return t_field'(int'($urandom_range(4000)) - 2000);
            default: begin
                case ($urandom_range(5))
                    0:       return 16'sh8000;
                    1:       return 16'sh8001;
                    2:       return -16'sd1;
                    3:       return 16'sd0;
                    4:       return 16'sh7ffe;
                    default: return 16'sh7fff;
                endcase
            end
        endcase
    endfunction

    function automatic t_field clamp_coord(longint v);
        if (v > 32767)  return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return t_field'(v);
    endfunction

    task automatic push_load(t_slot s, t_field ax, t_field ay, t_field bx, t_field by);
        t_request rq;
        rq.kind = REQ_LOAD;
        rq.slot = s;
        rq.ax   = ax;
        rq.ay   = ay;
        rq.bx   = bx;
        rq.by   = by;
        pending_reqs.insert(pending_reqs.size(), rq);
        scene_tab[s].p1.x = ax;
        scene_tab[s].p1.y = ay;
        scene_tab[s].p2.x = bx;
        scene_tab[s].p2.y = by;
        scene_loaded[s]   = 1'b1;
    endtask

    task automatic push_query(t_field ax, t_field ay, t_field bx, t_field by);
        t_request rq;
        rq.kind = REQ_QUERY;
        rq.slot = t_slot'($urandom_range(63));  // ignored by the block
        rq.ax   = ax;
        rq.ay   = ay;
        rq.bx   = bx;
        rq.by   = by;
        pending_reqs.insert(pending_reqs.size(), rq);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_verdicts.size() != 0)
            @(posedge i_clk);
    endtask

    // Single config transfer; block is idle when this is called
    task automatic write_active(t_active value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        active_cnt = value;
        cfg_ch.valid <= 1'b0;
    endtask

    // Preload, one config setting, then a batch of random loads and queries
    task automatic run_phase(int count, int n_items, t_pace p, bit squeeze);
        int       need;
        int       roll;
        t_geo     g;
        t_field   ax, ay, bx, by;
        longint   mx, my, dx, dy;
        t_segment s;
        need = (count > MAX_OBSTACLES) ? MAX_OBSTACLES : count;
        // every slot a query will read must hold a segment first
        for (int i = 0; i < need; i++) begin
            if (!scene_loaded[i]) begin
                g = pick_geo();
                push_load(t_slot'(i), pick_coord(g), pick_coord(g), pick_coord(g),
                          pick_coord(g));
            end
        end
        wait_drained();
        write_active(t_active'(count));
        pace = p;
        for (int n = 0; n < n_items; n++) begin
            g  = pick_geo();
            ax = pick_coord(g);
            ay = pick_coord(g);
            bx = pick_coord(g);
            by = pick_coord(g);
            if ($urandom_range(99) < 30) begin
                if ($urandom_range(9) == 0) begin
                    bx = ax;
                    by = ay;
                end
                push_load(t_slot'($urandom_range(63)), ax, ay, bx, by);
            end else begin
                roll = $urandom_range(99);
                if (need > 0) begin
                    s  = scene_tab[$urandom_range(need - 1)];
                    mx = ($signed(s.p1.x) + longint'($signed(s.p2.x))) >>> 1;
                    my = ($signed(s.p1.y) + longint'($signed(s.p2.y))) >>> 1;
                    if (roll < 45) begin
                        // short edge through the obstacle midpoint
                        dx = int'($urandom_range(600)) - 300;
                        dy = int'($urandom_range(600)) - 300;
                        ax = clamp_coord(mx + dx);
                        ay = clamp_coord(my + dy);
                        bx = clamp_coord(mx - dx);
                        by = clamp_coord(my - dy);
                    end else if (roll < 60) begin
                        // starts on an obstacle endpoint
                        ax = s.p1.x;
                        ay = s.p1.y;
                    end else if (roll < 70) begin
                        // collinear overlap beyond both ends
                        ax = clamp_coord(2 * longint'($signed(s.p1.x)) - $signed(s.p2.x));
                        ay = clamp_coord(2 * longint'($signed(s.p1.y)) - $signed(s.p2.y));
                        bx = clamp_coord(2 * longint'($signed(s.p2.x)) - $signed(s.p1.x));
                        by = clamp_coord(2 * longint'($signed(s.p2.y)) - $signed(s.p1.y));
                    end else if (roll < 75) begin
                        // ends at (or next to) the obstacle interior
                        ax = clamp_coord(mx);
                        ay = clamp_coord(my);
                    end
                end
                if ($urandom_range(19) == 0) begin
                    bx = ax;
                    by = ay;
                end
                push_query(ax, ay, bx, by);
            end
        end
        // receiver stalls long enough for the request side to back up
        if (squeeze)
            holds_asked++;
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Request driver: one transfer per handshake, payload held while stalled
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : req_driver
        t_request nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready)
                expected_verdicts.insert(expected_verdicts.size(),
                                         predict_outcome(pending_reqs.pop_front()));
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct(pace, 1'b0)) begin
                    nxt = pending_reqs[0];
                    req_ch.valid    <= 1'b1;
                    req_ch.req_type <= nxt.kind;
                    req_ch.slot     <= nxt.slot;
                    req_ch.first_x  <= nxt.ax;
                    req_ch.first_y  <= nxt.ay;
                    req_ch.second_x <= nxt.bx;
                    req_ch.second_y <= nxt.by;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: in-order compare against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : rsp_monitor
        t_verdict want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status %0d slot %0d",
                                              rsp_ch.status, rsp_ch.hit_slot));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  rsp_ch.status, want.status));
                    if (rsp_ch.hit_slot !== want.hit_slot)
                        report_mismatch($sformatf("hit_slot got %0d want %0d",
                                                  rsp_ch.hit_slot, want.hit_slot));
                end
                result_count++;
            end
            rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(pace, 1'b1));
        end
    end

    // Long receiver hold-off, counted here on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_LOAD;
        req_ch.slot     = '0;
        req_ch.first_x  = '0;
        req_ch.first_y  = '0;
        req_ch.second_x = '0;
        req_ch.second_y = '0;
        rsp_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        active_cnt      = '0;
        for (int i = 0; i < MAX_OBSTACLES; i++)
            obstacle_tab[i] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero count reports clear, then a small hand-built scene
        push_query(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        push_load(6'd0, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        push_load(6'd1, 16'sd0, 16'sd0, 16'sd100, 16'sd0);
        push_load(6'd2, 16'sd5, 16'sd5, 16'sd5, 16'sd5);
        push_load(6'd3, 16'sd0, -16'sd10, 16'sd0, 16'sd10);
        push_load(6'd63, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
        wait_drained();
        write_active(t_active'(4));
        push_query(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);  // full diagonal cut
        push_query(16'sd50, 16'sd0, 16'sd50, 16'sd20);            // endpoint on segment
        push_query(-16'sd50, 16'sd0, 16'sd200, 16'sd0);           // collinear overlap
        push_query(16'sd5, 16'sd5, 16'sd5, 16'sd5);               // zero-length edge
        push_query(16'sd50, -16'sd5, 16'sd50, 16'sd5);            // clean crossing
        push_query(16'sd0, 16'sd5, 16'sd10, 16'sd5);              // through the point obstacle
        push_query(-16'sd3, -16'sd3, 16'sd3, 16'sd3);
        push_query(16'sd100, 16'sd0, 16'sd120, 16'sd10);          // touches far endpoint
        push_query(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff);   // corner touch
        push_query(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);   // identical segment
        wait_drained();

        // Random phases: sender light / receiver heavy idling
        run_phase(1, 150, PACE_RX_SLOW, 1'b0);
        run_phase(5, 250, PACE_RX_SLOW, 1'b0);
        run_phase(12, 250, PACE_RX_SLOW, 1'b0);
        // sender heavy / receiver light idling
        run_phase(3, 250, PACE_TX_SLOW, 1'b0);
        run_phase(20, 200, PACE_TX_SLOW, 1'b0);
        run_phase(64, 40, PACE_TX_SLOW, 1'b0);
        // no idling on either side
        run_phase(8, 300, PACE_FULL, 1'b1);
        run_phase(127, 40, PACE_FULL, 1'b0);
        run_phase(30, 200, PACE_FULL, 1'b0);
        run_phase(2, 200, PACE_FULL, 1'b0);
        run_phase(0, 50, PACE_FULL, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_verdicts.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
